// ===== hw/rtl/fpn_pkg.sv =====
// ----------------------------------------------------------------------------
// fpn_pkg
// Shared constants, gradient selection and fade table for the fractal
// 2D gradient noise sampler.
// ----------------------------------------------------------------------------
package fpn_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int CONT_OCT    = 4;
	localparam int DET_OCT     = 2;
	localparam int CONT_SHIFT  = 7;
	localparam int DET_SHIFT   = 5;
	localparam int DET_BIAS    = 100;
	localparam int OUT_W       = 18;
	localparam int TOTAL_OCT   = CONT_OCT + DET_OCT;
	localparam int MAX_OCT     = (CONT_OCT > DET_OCT) ? CONT_OCT : DET_OCT;
	localparam int ACC_W       = 19 + MAX_OCT;
	localparam int FADE_IDX_W  = 7;
	localparam int FADE_W      = 17;
	localparam int LANE_W      = 20;
	localparam int MUL_W       = 32;
	localparam int OUT_MAX     = 131071;
	localparam int OUT_MIN     = -131072;

	// Reciprocal constants for the final divide by (2^octaves - 1)
	localparam longint CONT_D = (longint'(1) << CONT_OCT) - 1;
	localparam longint CONT_H = CONT_D / 2;
	localparam int     CONT_L = $clog2(CONT_D);
	localparam int     CONT_N = $clog2(CONT_D * 131072 + CONT_H + 1);
	localparam int     CONT_K = CONT_N + CONT_L;
	localparam longint CONT_M = ((longint'(1) << CONT_K) + CONT_D - 1) / CONT_D;

	localparam longint DET_D = (longint'(1) << DET_OCT) - 1;
	localparam longint DET_H = DET_D / 2;
	localparam int     DET_L = $clog2(DET_D);
	localparam int     DET_N = $clog2(DET_D * 131072 + DET_H + 1);
	localparam int     DET_K = DET_N + DET_L;
	localparam longint DET_M = ((longint'(1) << DET_K) + DET_D - 1) / DET_D;

	localparam logic [2:0] G_PP = 3'd0;
	localparam logic [2:0] G_NP = 3'd1;
	localparam logic [2:0] G_PN = 3'd2;
	localparam logic [2:0] G_NN = 3'd3;
	localparam logic [2:0] G_PX = 3'd4;
	localparam logic [2:0] G_NX = 3'd5;
	localparam logic [2:0] G_PZ = 3'd6;
	localparam logic [2:0] G_NZ = 3'd7;

	typedef logic [FADE_W-1:0] fade_lut_t [2**FADE_IDX_W];

	function automatic logic signed [18:0] grad(input logic [2:0] h,
			input logic signed [18:0] x, input logic signed [18:0] z);
		logic signed [18:0] r;
		case (h)
			G_PP: r = x + z;
			G_NP: r = z - x;
			G_PN: r = x - z;
			G_NN: r = -x - z;
			G_PX: r = x;
			G_NX: r = -x;
			G_PZ: r = z;
			G_NZ: r = -z;
			default: r = '0;
		endcase
		return r;
	endfunction

	// 6t^5 - 15t^4 + 10t^3 on t = i/128, rounded half up to FRAC_BITS bits
	function automatic fade_lut_t gen_fade();
		fade_lut_t lut;
		longint u;
		longint num;
		for (int i = 0; i < 2**FADE_IDX_W; i++) begin
			u = longint'(i);
			num = u * u * u * (u * (6 * u - 15 * 128) + 10 * 128 * 128);
			lut[i] = FADE_W'(((num << FRAC_BITS) + (longint'(1) << 34)) >> 35);
		end
		return lut;
	endfunction

endpackage

// ===== hw/rtl/fractal_perlin_2d_noise.sv =====
// ----------------------------------------------------------------------------
// fractal_perlin_2d_noise
// Fractal 2D gradient noise sampler with a loadable 256-entry permutation table.
// ----------------------------------------------------------------------------
// A transfer with tuser = 0 writes one permutation entry and gives no result. A
// transfer with tuser = 1 samples a column: four continental and two detail
// octaves run one after another, each stepping through the single-port table
// read (six reads) and the shared multiplier (three lerps); the continental and
// the detail octaves are each followed by their divide on that multiplier, and
// the output register is loaded last. Only one sample is in flight; the next
// item is taken while a finished result still waits on the output register,
// and a new result waits until that register is free. Table entries must be
// loaded before they are read.
module fractal_perlin_2d_noise (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic        s_tuser,   // action
	input  logic [79:0] s_tdata,   // column_x, column_z, table_index, table_value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // continental_noise, detail_noise, zero pad
);
	import fpn_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_OCT  = 4'b0010,
		S_DIV  = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic REG_OFFSET_X = 1'b0;
	localparam fade_lut_t FADE_LUT = gen_fade();

	state_t state_q;
	logic [3:0] step_q;
	logic [3:0] oct_q;
	logic       m_valid_q;
	logic [39:0] m_data_q;

	logic [11:0] offset_x_q, offset_z_q;
	logic [15:0] ux_q, uz_q;
	logic [7:0]  cellx_q, cellz_q;
	logic [15:0] fracx_q, fracz_q;
	logic [FADE_W-1:0] fadex_q, fadez_q;
	logic [7:0]  hx_q, hx1_q, aa_q, ab_q, ba_q, bb_q;
	logic signed [18:0] ga_q;
	logic signed [LANE_W-1:0] r1_q;
	logic signed [2*MUL_W-1:0] p_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [OUT_W-1:0] cont_q;
	logic signed [OUT_W-1:0] det_q;

	logic [7:0] perm_mem [256];
	logic [7:0] rdata_q;
	logic [7:0] rd_addr;
	logic       wr_en;

	logic s_fire;
	logic is_cont;
	logic [3:0] k_oct;
	logic signed [4:0] shift;
	logic [7:0] bias;
	logic [7:0] cellx_c, cellz_c;
	logic [15:0] fracx_c, fracz_c;
	logic signed [18:0] x0, x1, z0, z1;
	logic signed [MUL_W-1:0] mul_a, mul_b;
	logic signed [2*MUL_W-1:0] rnd_full;
	logic signed [LANE_W-1:0] rnd;
	logic signed [LANE_W-1:0] r2;
	logic signed [LANE_W-1:0] noise_n;
	logic acc_neg;
	logic [ACC_W-1:0] mag, n_div;
	logic [2*MUL_W-1:0] q_full;
	logic signed [25:0] q_s;
	logic signed [OUT_W-1:0] sat;
	logic last_oct;

	assign s_tready = (state_q == S_IDLE);
	assign s_fire   = s_tvalid & s_tready;
	assign wr_en    = s_fire & (s_tuser == ACT_LOAD);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			perm_mem[s_tdata[71:64]] <= s_tdata[79:72];
		end
		rdata_q <= perm_mem[rd_addr];
	end

	always_comb begin
		is_cont = (oct_q < 4'(CONT_OCT));
		k_oct   = is_cont ? oct_q : oct_q - 4'(CONT_OCT);
		shift   = is_cont ? 5'(CONT_SHIFT) - 5'(k_oct) : 5'(DET_SHIFT) - 5'(k_oct);
		bias    = is_cont ? 8'd0 : 8'(DET_BIAS << k_oct);
		if (shift > 5'sd0) begin
			cellx_c = 8'(ux_q >> 4'(shift)) + bias;
			cellz_c = 8'(uz_q >> 4'(shift)) + bias;
			fracx_c = ux_q << (5'd16 - 5'(shift));
			fracz_c = uz_q << (5'd16 - 5'(shift));
		end else begin
			cellx_c = 8'(ux_q << 4'(-shift)) + bias;
			cellz_c = 8'(uz_q << 4'(-shift)) + bias;
			fracx_c = '0;
			fracz_c = '0;
		end
		last_oct = (oct_q == 4'(CONT_OCT - 1)) || (oct_q == 4'(TOTAL_OCT - 1));
	end

	always_comb begin
		case (step_q)
			4'd0: rd_addr = cellx_c;
			4'd1: rd_addr = cellx_q + 8'd1;
			4'd2: rd_addr = hx_q + cellz_q;
			4'd3: rd_addr = hx_q + cellz_q + 8'd1;
			4'd4: rd_addr = hx1_q + cellz_q;
			4'd5: rd_addr = hx1_q + cellz_q + 8'd1;
			default: rd_addr = cellx_c;
		endcase
	end

	assign x0 = $signed({3'b000, fracx_q});
	assign z0 = $signed({3'b000, fracz_q});
	assign x1 = x0 - 19'sd65536;
	assign z1 = z0 - 19'sd65536;

	assign rnd_full = (p_q + 64'sd32768) >>> FRAC_BITS;
	assign rnd      = rnd_full[LANE_W-1:0];
	assign r2       = LANE_W'(ga_q) + rnd;
	assign noise_n  = r1_q + rnd;

	assign acc_neg = acc_q[ACC_W-1];
	assign mag     = acc_neg ? ACC_W'(-acc_q) : ACC_W'(acc_q);
	assign n_div   = mag + (is_cont ? ACC_W'(CONT_H) : ACC_W'(DET_H));
	assign q_full  = is_cont ? (p_q >> CONT_K) : (p_q >> DET_K);
	assign q_s     = acc_neg ? -$signed({1'b0, q_full[24:0]}) : $signed({1'b0, q_full[24:0]});
	assign sat     = (q_s > 26'sd131071) ? OUT_W'(OUT_MAX) :
	                 (q_s < -26'sd131072) ? OUT_W'(OUT_MIN) : q_s[OUT_W-1:0];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == S_DIV) begin
			mul_a = MUL_W'(n_div);
			mul_b = is_cont ? MUL_W'(CONT_M) : MUL_W'(DET_M);
		end else begin
			case (step_q)
				4'd6: begin
					mul_a = MUL_W'(fadex_q);
					mul_b = MUL_W'(LANE_W'(grad(ba_q[2:0], x1, z0))
					        - LANE_W'(grad(aa_q[2:0], x0, z0)));
				end
				4'd7: begin
					mul_a = MUL_W'(fadex_q);
					mul_b = MUL_W'(LANE_W'(grad(bb_q[2:0], x1, z1))
					        - LANE_W'(grad(ab_q[2:0], x0, z1)));
				end
				4'd8: begin
					mul_a = MUL_W'(fadez_q);
					mul_b = MUL_W'(r2 - r1_q);
				end
				default: begin
					mul_a = '0;
					mul_b = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q <= '0;
			offset_z_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_OFFSET_X) begin
				offset_x_q <= cfg_data;
			end else begin
				offset_z_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			step_q    <= '0;
			oct_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					step_q <= '0;
					oct_q  <= '0;
					if (s_fire && s_tuser != ACT_LOAD) begin
						state_q <= S_OCT;
					end
				end
				S_OCT: begin
					if (step_q == 4'd9) begin
						step_q <= '0;
						if (last_oct) begin
							state_q <= S_DIV;
						end else begin
							oct_q <= oct_q + 4'd1;
						end
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				S_DIV: begin
					if (step_q == 4'd1) begin
						step_q <= '0;
						if (is_cont) begin
							oct_q   <= oct_q + 4'd1;
							state_q <= S_OCT;
						end else begin
							state_q <= S_OUT;
						end
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				S_OUT: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		p_q <= mul_a * mul_b;
		if (s_fire) begin
			ux_q  <= s_tdata[15:0] + {4'b0000, offset_x_q};
			uz_q  <= s_tdata[47:32] + {4'b0000, offset_z_q};
			acc_q <= '0;
		end
		if (state_q == S_OCT) begin
			case (step_q)
				4'd0: begin
					cellx_q <= cellx_c;
					cellz_q <= cellz_c;
					fracx_q <= fracx_c;
					fracz_q <= fracz_c;
					fadex_q <= FADE_LUT[fracx_c[15:9]];
					fadez_q <= FADE_LUT[fracz_c[15:9]];
				end
				4'd1: hx_q  <= rdata_q;
				4'd2: hx1_q <= rdata_q;
				4'd3: aa_q  <= rdata_q;
				4'd4: ab_q  <= rdata_q;
				4'd5: ba_q  <= rdata_q;
				4'd6: begin
					bb_q <= rdata_q;
					ga_q <= grad(aa_q[2:0], x0, z0);
				end
				4'd7: begin
					r1_q <= LANE_W'(ga_q) + rnd;
					ga_q <= grad(ab_q[2:0], x0, z1);
				end
				4'd8: r1_q <= r1_q;
				4'd9: acc_q <= (acc_q <<< 1) + ACC_W'(noise_n);
				default: r1_q <= r1_q;
			endcase
		end
		if (state_q == S_DIV && step_q == 4'd1) begin
			if (is_cont) begin
				cont_q <= sat;
				acc_q  <= '0;
			end else begin
				det_q <= sat;
			end
		end
		if (state_q == S_OUT && (!m_valid_q || m_tready)) begin
			m_data_q <= {4'b0000, det_q, cont_q};
		end
	end

	a_sample_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && s_tuser != ACT_LOAD) |=> (state_q == S_OCT && oct_q == 4'd0 && step_q == 4'd0))
		else $error("sample did not start at first octave");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OCT) |-> (step_q <= 4'd9 && oct_q < 4'(TOTAL_OCT)))
		else $error("octave sequencer out of range");

	a_out_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && (!m_valid_q || m_tready)) |=> (m_tvalid && state_q == S_IDLE))
		else $error("result not presented");

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_IDLE))
		else $error("table write while busy");

endmodule

// ===== sim/tb_fractal_perlin_2d_noise.sv =====
// ----------------------------------------------------------------------------
// tb_fractal_perlin_2d_noise
// Self-checking bench for the fractal 2D gradient noise sampler. The full
// permutation table is loaded first, so no sample ever reads an unloaded
// entry. Directed columns and offsets cover the coordinate extremes and both
// register extremes. Random columns follow, mixed with table reloads, across
// several offset settings. A bit-exact noise predictor computes each expected
// result when its transfer is accepted, and a monitor compares every output
// transfer with the oldest expected result.
// ----------------------------------------------------------------------------
module tb_fractal_perlin_2d_noise;
	import fpn_pkg::*;

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;
	localparam logic REG_OFFSET_X = 1'b0;
	localparam logic REG_OFFSET_Z = 1'b1;

	typedef struct {
		logic signed [OUT_W-1:0] continental;
		logic signed [OUT_W-1:0] detail;
	} noise_pair_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [11:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic        s_tuser;
	logic [79:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;

	logic [7:0]  perm_copy [256];
	logic [11:0] off_x_copy;
	logic [11:0] off_z_copy;
	noise_pair_t noise_expected [$];
	int          fail_count;
	bit          no_idle;

	fractal_perlin_2d_noise DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("Regression FAIL");
		$finish;
	end

	// ---------------- predictor ----------------
	function automatic longint grad_dot(logic [7:0] h, longint x, longint z);
		case (h[2:0])
			G_PP: return x + z;
			G_NP: return z - x;
			G_PN: return x - z;
			G_NN: return -x - z;
			G_PX: return x;
			G_NX: return -x;
			G_PZ: return z;
			default: return -z;
		endcase
	endfunction

	function automatic longint lerp_q(longint t, longint a, longint b);
		return a + ((t * (b - a) + 32768) >>> FRAC_BITS);
	endfunction

	function automatic longint fade_q(longint m, int s);
		longint q, num;
		if (s == 0) return 0;
		q = longint'(1) << s;
		num = m * m * m * (m * (6 * m - 15 * q) + 10 * q * q);
		return ((num << FRAC_BITS) + (longint'(1) << (5 * s - 1))) >> (5 * s);
	endfunction

	function automatic longint octave_noise(bit [63:0] ux, bit [63:0] uz, int sh, bit [63:0] b);
		bit [63:0] mask;
		logic [7:0] cx, cz, hx, hx1, aa, ab, ba, bb;
		longint fx, fz, tx, tz, one, r1, r2;
		one = longint'(1) << FRAC_BITS;
		mask = (64'd1 << sh) - 1;
		cx = 8'((ux >> sh) + b);
		cz = 8'((uz >> sh) + b);
		fx = longint'((ux & mask) << (FRAC_BITS - sh));
		fz = longint'((uz & mask) << (FRAC_BITS - sh));
		tx = fade_q(longint'(ux & mask), sh);
		tz = fade_q(longint'(uz & mask), sh);
		hx  = perm_copy[cx];
		hx1 = perm_copy[8'(cx + 8'd1)];
		aa = perm_copy[8'(hx + cz)];
		ab = perm_copy[8'(hx + cz + 8'd1)];
		ba = perm_copy[8'(hx1 + cz)];
		bb = perm_copy[8'(hx1 + cz + 8'd1)];
		r1 = lerp_q(tx, grad_dot(aa, fx, fz), grad_dot(ba, fx - one, fz));
		r2 = lerp_q(tx, grad_dot(ab, fx, fz - one), grad_dot(bb, fx - one, fz - one));
		return lerp_q(tz, r1, r2);
	endfunction

	function automatic logic signed [OUT_W-1:0] fractal_noise(bit [63:0] ux, bit [63:0] uz,
			int octaves, int base_sh, bit [63:0] bias);
		longint acc, d, r;
		acc = 0;
		for (int k = 0; k < octaves; k++)
			acc = acc * 2 + octave_noise(ux, uz, base_sh - k, bias << k);
		d = (longint'(1) << octaves) - 1;
		if (acc >= 0) r = (acc + d / 2) / d;
		else r = -((-acc + d / 2) / d);
		if (r > OUT_MAX) r = OUT_MAX;
		if (r < OUT_MIN) r = OUT_MIN;
		return OUT_W'(r);
	endfunction

	function automatic noise_pair_t predict_column(logic [31:0] x, logic [31:0] z);
		noise_pair_t p;
		bit [63:0] ux, uz;
		ux = 64'(longint'($signed(x)) + longint'(off_x_copy));
		uz = 64'(longint'($signed(z)) + longint'(off_z_copy));
		p.continental = fractal_noise(ux, uz, CONT_OCT, CONT_SHIFT, 0);
		p.detail = fractal_noise(ux, uz, DET_OCT, DET_SHIFT, DET_BIAS);
		return p;
	endfunction

	// ---------------- output side ----------------
	always @(posedge clk) begin
		if (!arst_n) m_tready <= 1'b0;
		else m_tready <= no_idle || ($urandom_range(99) >= 34);
	end

	always @(posedge clk) begin
		noise_pair_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (noise_expected.size() == 0) begin
				$error("result transfer with no sample pending: %h", m_tdata);
				fail_count++;
			end else begin
				e = noise_expected.pop_front();
				if (m_tdata[17:0] !== e.continental) begin
					$error("continental_noise expected %0d got %0d", e.continental,
						$signed(m_tdata[17:0]));
					fail_count++;
				end
				if (m_tdata[35:18] !== e.detail) begin
					$error("detail_noise expected %0d got %0d", e.detail,
						$signed(m_tdata[35:18]));
					fail_count++;
				end
			end
		end
	end

	// ---------------- input side ----------------
	task automatic send_item(logic act, logic [31:0] x, logic [31:0] z,
			logic [7:0] idx, logic [7:0] val);
		int gap;
		gap = (!no_idle && $urandom_range(99) < 34) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {val, idx, z, x};
		do @(posedge clk); while (!s_tready);
		if (act == ACT_LOAD) perm_copy[idx] = val;
		else noise_expected.push_back(predict_column(x, z));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		wait (noise_expected.size() == 0);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_offsets(logic [11:0] ox, logic [11:0] oz);
		drain();
		cfg_we <= 1'b1; cfg_index <= REG_OFFSET_X; cfg_data <= ox;
		@(posedge clk);
		cfg_index <= REG_OFFSET_Z; cfg_data <= oz;
		@(posedge clk);
		cfg_we <= 1'b0;
		off_x_copy = ox;
		off_z_copy = oz;
	endtask

	task automatic sample(logic [31:0] x, logic [31:0] z);
		send_item(ACT_SAMPLE, x, z, 8'($urandom), 8'($urandom));
	endtask

	task automatic test_table_load();
		logic [7:0] shuffled [256];
		logic [7:0] t;
		int j;
		for (int i = 0; i < 256; i++) shuffled[i] = 8'(i);
		for (int i = 255; i > 0; i--) begin
			j = $urandom_range(i);
			t = shuffled[i]; shuffled[i] = shuffled[j]; shuffled[j] = t;
		end
		for (int i = 0; i < 256; i++)
			send_item(ACT_LOAD, $urandom, $urandom, 8'(i), shuffled[i]);
	endtask

	task automatic test_coordinate_extremes();
		sample(32'h0, 32'h0);
		sample(32'h8000_0000, 32'h7FFF_FFFF);
		sample(32'h7FFF_FFFF, 32'h8000_0000);
		sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		sample(32'h7F, 32'h80);
		sample(32'hFFFF_FF80, 32'h3F);
		sample(32'h1F, 32'hFFFF_FFE1);
		sample(32'h8000_0000, 32'h8000_0000);
		sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
	endtask

	task automatic test_offset_extremes();
		write_offsets(12'hFFF, 12'hFFF);
		sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		sample(32'hFFFF_F001, 32'hFFFF_F001);
		sample(32'h8000_0000, 32'h0);
		write_offsets(12'hFFF, 12'h000);
		sample(32'h7FFF_FFFF, 32'h8000_0000);
		sample(32'h1234_5678, 32'hFFFF_FFFF);
		write_offsets(12'h000, 12'hFFF);
		sample(32'h8000_0000, 32'h7FFF_FFFF);
		sample(32'h0, 32'hFFFF_F001);
		// table reload between samples
		send_item(ACT_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'h00);
		send_item(ACT_LOAD, 32'h0, 32'h0, 8'h00, 8'hFF);
		sample(32'hFFFF_FF00, 32'h100);
	endtask

	task automatic test_random_columns();
		logic [31:0] x, z;
		for (int n = 0; n < 130; n++) begin
			if (n % 50 == 0) write_offsets(12'($urandom), 12'($urandom));
			no_idle = (n >= 30 && n < 90);
			if ($urandom_range(9) == 0) begin
				send_item(ACT_LOAD, $urandom, $urandom, 8'($urandom), 8'($urandom));
			end else begin
				case ($urandom_range(3))
					0: begin x = $urandom; z = $urandom; end
					1: begin
						x = 32'($signed($urandom_range(4000)) - 2000);
						z = 32'($signed($urandom_range(4000)) - 2000);
					end
					2: begin
						x = {$urandom_range(1) ? 25'h1FF_FFFF : 25'h0, 7'($urandom)};
						z = {$urandom_range(1) ? 25'h1FF_FFFF : 25'h0, 7'($urandom)};
					end
					default: begin
						x = {1'($urandom_range(1)), 31'($urandom)};
						z = 32'($urandom_range(300));
					end
				endcase
				sample(x, z);
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		fail_count = 0;
		no_idle = 1'b0;
		off_x_copy = '0;
		off_z_copy = '0;
		for (int i = 0; i < 256; i++) perm_copy[i] = '0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_OFFSET_X;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tuser = ACT_LOAD;
		s_tdata = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_table_load();
		test_coordinate_extremes();
		test_offset_extremes();
		test_random_columns();
		write_offsets(12'h000, 12'h000);
		sample(32'h8000_0000, 32'hFFFF_FFFF);
		drain();
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/fpn_pkg.sv
hw/rtl/fractal_perlin_2d_noise.sv
sim/tb_fractal_perlin_2d_noise.sv
